// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/rit_pkg.sv =====
// Shared constants, codes and transaction types of the recent id table.
`default_nettype none

package rit_pkg;

  localparam int LIST_DEPTH    = 16;
  localparam int IDX_W         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W         = $clog2(LIST_DEPTH + 1);
  localparam int KEY_W         = 128;
  localparam int HALF_W        = 64;
  localparam int ENTRY_COUNT_W = 5;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 64;

  // Operation codes
  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  // Key kinds
  localparam logic [1:0] KIND_NONE      = 2'd0;
  localparam logic [1:0] KIND_MALFORMED = 2'd1;
  localparam logic [1:0] KIND_VALID     = 2'd2;

  // Own-id modes
  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_SPECIFIC = 2'd1;
  localparam logic [1:0] MODE_WILDCARD = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_OWN_HIGH = 2'd0;
  localparam logic [1:0] REG_OWN_LOW  = 2'd1;
  localparam logic [1:0] REG_OWN_MODE = 2'd2;

  typedef struct packed {
    logic              op;
    logic [1:0]        key_kind;
    logic [HALF_W-1:0] key_high;
    logic [HALF_W-1:0] key_low;
  } in_item_t;

  typedef struct packed {
    logic                     match;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [HALF_W-1:0] own_id_high;
    logic [HALF_W-1:0] own_id_low;
    logic [1:0]        own_id_mode;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/rit_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module rit_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rit_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rit_pkg::DATA_W-1:0] pwdata,
  output logic      [rit_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output rit_pkg::cfg_t                   cfg_o
);

  rit_pkg::cfg_t cfg_q;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        rit_pkg::REG_OWN_HIGH: cfg_q.own_id_high <= pwdata;
        rit_pkg::REG_OWN_LOW:  cfg_q.own_id_low  <= pwdata;
        rit_pkg::REG_OWN_MODE: cfg_q.own_id_mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_idx)
      rit_pkg::REG_OWN_HIGH: prdata = cfg_q.own_id_high;
      rit_pkg::REG_OWN_LOW:  prdata = cfg_q.own_id_low;
      rit_pkg::REG_OWN_MODE: prdata = {{(rit_pkg::DATA_W-2){1'b0}}, cfg_q.own_id_mode};
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/recent_id_table_core.sv =====
// Recent id table: move-to-front list of 128-bit ids walked by one shared comparator.
// A transaction is accepted in idle, then passes the decide state, an optional walk over the
// held entries and the done state; the walk does one entry compare per cycle.
// A new transaction is taken only once the result is loaded; input stall stays high from
// accept to result load, and longer while a waiting result is stalled.
// Reset clears the entry count, the sequencer and the output valid; list entries are
// not cleared, since only entries below the count are ever used.
`default_nettype none

module recent_id_table_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire rit_pkg::in_item_t          in_item_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output rit_pkg::out_item_t              out_item_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rit_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rit_pkg::DATA_W-1:0] pwdata,
  output logic      [rit_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  rit_pkg::cfg_t cfg;

  logic [1:0]                 state_q, state_d;
  logic [rit_pkg::CNT_W-1:0]  held_q, held_d;
  logic [rit_pkg::CNT_W-1:0]  idx_q, idx_d;
  logic                       match_q, match_d;
  logic                       out_valid_q, out_valid_d;
  rit_pkg::out_item_t         out_item_q, out_item_d;
  logic                       op_q;
  logic [1:0]                 kind_q;
  logic [rit_pkg::KEY_W-1:0]  key_q;
  logic [rit_pkg::KEY_W-1:0]  carry_q, carry_d;
  logic [rit_pkg::KEY_W-1:0]  rdata_q;
  logic [rit_pkg::KEY_W-1:0]  mem_q [rit_pkg::LIST_DEPTH];

  logic                             in_accept;
  logic [rit_pkg::KEY_W-1:0]        cmp_b;
  logic                             cmp_eq;
  logic                             at_end;
  logic [rit_pkg::CNT_W-1:0]        idx_inc;
  logic [rit_pkg::IDX_W-1:0]        raddr;
  logic                             we;
  logic [rit_pkg::CNT_W+rit_pkg::ENTRY_COUNT_W-1:0] cnt_ext;

  rit_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  function automatic logic [rit_pkg::CNT_W-1:0] held_inc(
    input logic [rit_pkg::CNT_W-1:0] cnt
  );
    return cnt + rit_pkg::CNT_W'(1);
  endfunction

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Shared comparator: own id while deciding, the read entry while walking
  assign cmp_b   = (state_q == ST_DECIDE) ? {cfg.own_id_high, cfg.own_id_low} : rdata_q;
  assign cmp_eq  = (key_q == cmp_b);
  assign at_end  = (idx_q == held_q);
  assign idx_inc = idx_q + rit_pkg::CNT_W'(1);

  // Prefetch the next entry while walking, else the front entry
  assign raddr   = (state_q == ST_WALK) ? idx_inc[rit_pkg::IDX_W-1:0] : '0;
  assign cnt_ext = {{rit_pkg::ENTRY_COUNT_W{1'b0}}, held_q};

  // Sequencer
  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    idx_d       = idx_q;
    match_d     = match_q;
    carry_d     = carry_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    we          = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          idx_d   = '0;
          carry_d = {in_item_i.key_high, in_item_i.key_low};
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        match_d = 1'b0;
        state_d = ST_DONE;
        if (op_q == rit_pkg::OP_QUERY) begin
          if (kind_q == rit_pkg::KIND_NONE || cfg.own_id_mode == rit_pkg::MODE_WILDCARD) begin
            match_d = 1'b1;
          end else if (kind_q != rit_pkg::KIND_VALID) begin
            match_d = 1'b0;
          end else if (cfg.own_id_mode == rit_pkg::MODE_SPECIFIC && cmp_eq) begin
            match_d = 1'b1;
          end else if (held_q != '0) begin
            state_d = ST_WALK;
          end
        end else if (kind_q == rit_pkg::KIND_VALID) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (at_end) begin
          // Key absent: on a record, append the carried entry unless the list is full
          match_d = 1'b0;
          state_d = ST_DONE;
          if (op_q == rit_pkg::OP_RECORD &&
              held_q < rit_pkg::CNT_W'(rit_pkg::LIST_DEPTH)) begin
            we     = 1'b1;
            held_d = held_inc(held_q);
          end
        end else begin
          // On a record, shift the carried entry into this slot and carry the old one on
          if (op_q == rit_pkg::OP_RECORD) begin
            we      = 1'b1;
            carry_d = rdata_q;
          end
          if (cmp_eq) begin
            match_d = 1'b1;
            state_d = ST_DONE;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_item_d.match       = match_q;
          out_item_d.entry_count = cnt_ext[rit_pkg::ENTRY_COUNT_W-1:0];
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    match_q    <= match_d;
    carry_q    <= carry_d;
    out_item_q <= out_item_d;
    if (in_accept) begin
      op_q   <= in_item_i.op;
      kind_q <= in_item_i.key_kind;
      key_q  <= {in_item_i.key_high, in_item_i.key_low};
    end
  end

  // List storage: at most one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[idx_q[rit_pkg::IDX_W-1:0]] <= carry_q;
    end
    rdata_q <= mem_q[raddr];
  end

endmodule

`default_nettype wire

// ===== src/rit_checker.sv =====
// Port-level checker for the recent id table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module rit_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire rit_pkg::out_item_t out_item_o
);

  logic in_acc;
  logic cnt_ok;

  assign in_acc = in_valid_i & ~in_stall_o;
  assign cnt_ok = ({1'b0, out_item_o.entry_count} <=
                   (rit_pkg::ENTRY_COUNT_W + 1)'(rit_pkg::LIST_DEPTH));

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  // The table is busy right after taking a transaction
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o)
  // No result appears in the cycle after an accept
  `ASSERT_NEXT(a_no_instant_result, clk_i, rst_ni, in_acc, !$rose(out_valid_o))
  // The reported count never exceeds the list depth
  `ASSERT_SAME(a_count_bound, clk_i, rst_ni, out_valid_o, cnt_ok)

endmodule

bind recent_id_table_core rit_checker u_rit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
